### sv/d96_pkg.sv
// ----------------------------------------------------------------------------
// d96_pkg: shared types and constants for decimal96_to_int32_truncate
// Request structs for both channels and the divide-by-ten constants.
// ----------------------------------------------------------------------------
package d96_pkg;

	// input request: 96-bit mantissa, scale and sign
	typedef struct packed {
		logic [31:0] mantissa_low;
		logic [31:0] mantissa_mid;
		logic [31:0] mantissa_high;
		logic [7:0]  scale;
		logic        negative;
	} in_t;

	// output request: truncated integer and error flag
	typedef struct packed {
		logic signed [31:0] int_value;
		logic               error;
	} out_t;

	localparam int MantW     = 96;
	localparam int ChunkW    = 16;
	localparam int Chunks    = MantW / ChunkW;
	localparam int ChunkCntW = $clog2(Chunks);
	localparam int RemW      = 4;
	localparam int CurW      = RemW + ChunkW;
	localparam int DivCntW   = 5;

	// largest scale that is accepted
	localparam logic [7:0] ScaleMax = 8'd28;

	// ceil(2^23 / 10): exact quotient for every dividend below 2^22
	localparam int              RecipShift = 23;
	localparam logic [CurW-1:0] Recip      = CurW'(838861);

	localparam logic [ChunkCntW-1:0] ChunkLast = ChunkCntW'(Chunks - 1);

endpackage

### sv/d96_div10.sv
// ----------------------------------------------------------------------------
// d96_div10: one 16-bit step of a long division by ten
// Takes the running remainder and the next chunk, gives quotient chunk and
// new remainder, using a reciprocal multiply and a shift-subtract remainder.
// ----------------------------------------------------------------------------
module d96_div10
	import d96_pkg::*;
(
	input  logic [RemW-1:0]   rem_in,
	input  logic [ChunkW-1:0] chunk,
	output logic [ChunkW-1:0] quot,
	output logic [RemW-1:0]   rem_out
);

	logic [CurW-1:0]   cur;
	logic [2*CurW-1:0] prod;
	logic [CurW-1:0]   quot_ext;
	logic [CurW-1:0]   back;

	// dividend below 10 * 2^16, so the quotient fits one chunk
	assign cur  = {rem_in, chunk};
	assign prod = {{CurW{1'b0}}, cur} * {{CurW{1'b0}}, Recip};
	assign quot = prod[RecipShift +: ChunkW];

	// remainder = dividend - 10 * quotient
	assign quot_ext = {{RemW{1'b0}}, quot};
	assign back     = cur - (quot_ext << 3) - (quot_ext << 1);
	assign rem_out  = back[RemW-1:0];

endmodule

### sv/decimal96_to_int32_truncate.sv
// ----------------------------------------------------------------------------
// decimal96_to_int32_truncate: 96-bit decimal to int32, truncating
// Divides the mantissa by ten scale times and range checks the quotient.
// ----------------------------------------------------------------------------
//  channel | signals                           | direction
//  --------+-----------------------------------+----------
//  in      | in_valid, in_ready, in_data       | request in
//  out     | out_valid, out_ready, out_data    | request out
//
//  After accept a request passes through RUN, one division per unit of scale,
//  then FIN, which writes the result; a scale of zero or above 28 skips RUN.
//  The single 16-bit divide-by-ten unit handles one chunk of the 96-bit
//  mantissa per cycle, six chunks per division.
//  in_ready is high only while idle; a held result in the output register
//  does not block the next accept, only the final write of the next result.
//  Reset clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
module decimal96_to_int32_truncate
	import d96_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	typedef enum logic [1:0] {
		IDLE,
		RUN,
		FIN
	} state_t;

	state_t                state_q;
	logic [MantW-1:0]      m_q;
	logic [RemW-1:0]       rem_q;
	logic [ChunkCntW-1:0]  chunk_q;
	logic [DivCntW-1:0]    div_cnt_q;
	logic                  neg_q;
	logic                  bad_q;
	logic                  out_valid_q;
	out_t                  out_q;

	logic [ChunkW-1:0]     quot;
	logic [RemW-1:0]       rem_n;
	logic [31:0]           limit;
	logic                  fits;
	out_t                  result;
	logic                  bad_scale;

	// shared divide-by-ten step on the top chunk
	d96_div10 u_div10 (
		.rem_in  (rem_q),
		.chunk   (m_q[MantW-1 -: ChunkW]),
		.quot    (quot),
		.rem_out (rem_n)
	);

	// range check and sign on the final quotient
	always_comb begin
		limit            = {neg_q, {31{~neg_q}}};
		fits             = (m_q[MantW-1:32] == '0) && (m_q[31:0] <= limit);
		result.error     = bad_q || !fits;
		result.int_value = '0;
		if (!result.error) begin
			result.int_value = neg_q ? (32'd0 - m_q[31:0]) : m_q[31:0];
		end
	end

	assign bad_scale = in_data.scale > ScaleMax;

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			m_q         <= '0;
			rem_q       <= '0;
			chunk_q     <= '0;
			div_cnt_q   <= '0;
			neg_q       <= 1'b0;
			bad_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// drained result; the finish state refills the register itself
			if (out_valid_q && out_ready && (state_q != FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						m_q       <= {in_data.mantissa_high, in_data.mantissa_mid,
							in_data.mantissa_low};
						neg_q     <= in_data.negative;
						bad_q     <= bad_scale;
						div_cnt_q <= in_data.scale[DivCntW-1:0];
						chunk_q   <= '0;
						rem_q     <= '0;
						if (bad_scale || in_data.scale == 8'd0) begin
							state_q <= FIN;
						end else begin
							state_q <= RUN;
						end
					end
				end
				RUN: begin
					// rotate quotient chunks in at the bottom
					m_q <= {m_q[MantW-ChunkW-1:0], quot};
					if (chunk_q == ChunkLast) begin
						chunk_q   <= '0;
						rem_q     <= '0;
						div_cnt_q <= div_cnt_q - 1'b1;
						if (div_cnt_q == DivCntW'(1)) begin
							state_q <= FIN;
						end
					end else begin
						chunk_q <= chunk_q + 1'b1;
						rem_q   <= rem_n;
					end
				end
				FIN: begin
					if (!out_valid_q || out_ready) begin
						out_q       <= result;
						out_valid_q <= 1'b1;
						state_q     <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### sv/d96_checker.sv
// ----------------------------------------------------------------------------
// d96_checker: port-level checks for decimal96_to_int32_truncate
// Watches both channels and is bound to the top level.
// ----------------------------------------------------------------------------
module d96_checker
	import d96_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input in_t  in_data,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output request changed while stalled");

	// an error result carries zero
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.error |-> out_data.int_value == 32'sd0)
		else $error("error result with nonzero value");

	// busy after every accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accept");

	// a bad scale accepted while no result is held gives a result flagged as error
	a_bad_scale: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.scale > ScaleMax) && !out_valid
		|=> ##1 out_valid && out_data.error)
		else $error("bad scale not flagged");

endmodule

bind decimal96_to_int32_truncate d96_checker u_d96_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for decimal96_to_int32_truncate
// Sends a short table of edge-case requests and then randomly shaped ones,
// with random gaps on the input and random stalls on the output. Every
// result is checked against a table value or a local model of the truncation.
// ----------------------------------------------------------------------------
module tb_top;
	import d96_pkg::*;

	localparam int  ClkPeriod    = 12;
	localparam int  RandomCount  = 1130;
	localparam int  CalmTail     = 150;
	localparam int  DrainCycles  = 200;
	localparam int  MaxReports   = 10;
	localparam logic ConvOk      = 1'b0;
	localparam logic ConvErr     = 1'b1;
	localparam logic [31:0] IntMax = 32'h7FFF_FFFF;
	localparam logic [31:0] IntMin = 32'h8000_0000;

	// one line of the directed table
	typedef struct {
		in_t  req;
		bit   typed;
		out_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	out_t     pending_results[$];
	dir_row_t dir_rows[$];
	int       mismatch_cnt = 0;
	int       ok_cnt       = 0;
	int       err_cnt      = 0;
	int       stall_left   = 0;
	bit       idle_on;

	decimal96_to_int32_truncate u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #(ClkPeriod / 2) clk = ~clk;
	end

	// ten to the power n, wide enough to never wrap for the scales used
	function automatic logic [127:0] pow10(int n);
		logic [127:0] v;
		v = 128'd1;
		repeat (n) v = v * 128'd10;
		return v;
	endfunction

	function automatic in_t make_req(logic [95:0] m, logic [7:0] s, logic neg);
		in_t r;
		r.mantissa_low  = m[31:0];
		r.mantissa_mid  = m[63:32];
		r.mantissa_high = m[95:64];
		r.scale         = s;
		r.negative      = neg;
		return r;
	endfunction

	function automatic dir_row_t make_row(in_t r, bit typed, logic [31:0] v, logic e);
		dir_row_t row;
		row.req   = r;
		row.typed = typed;
		row.want  = {v, e};
		return row;
	endfunction

	// truncate toward zero, then range check against the signed 32-bit limit
	function automatic out_t truncate_to_int32(in_t r);
		logic [95:0] quot;
		logic [95:0] limit;
		out_t        res;
		res.int_value = '0;
		res.error     = ConvErr;
		if (r.scale > ScaleMax)
			return res;
		quot = {r.mantissa_high, r.mantissa_mid, r.mantissa_low};
		for (int i = 0; i < r.scale; i++)
			quot = quot / 96'd10;
		limit = 96'(IntMax) + 96'(r.negative);
		if (quot <= limit) begin
			res.int_value = r.negative ? -quot[31:0] : quot[31:0];
			res.error     = ConvOk;
		end
		return res;
	endfunction

	function automatic logic [95:0] rand96();
		return {$urandom, $urandom, $urandom};
	endfunction

	// random request, mostly built around the quotient that is produced
	function automatic in_t random_req();
		logic [127:0] quot;
		logic [127:0] m;
		int           s;
		int           kind;
		logic         neg;
		neg  = 1'($urandom_range(0, 1));
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1, 2, 3: begin
				// quotient right at the positive or negative limit
				s    = $urandom_range(0, 19);
				quot = 128'd2147483643 + 128'($urandom_range(0, 10));
				m    = quot * pow10(s) + (128'(rand96()) % pow10(s));
				return make_req(m[95:0], 8'(s), neg);
			end
			4, 5: begin
				// quotient of varied size, up to 32 bits
				s    = $urandom_range(0, 19);
				quot = 128'($urandom >> $urandom_range(0, 31));
				m    = quot * pow10(s) + (128'(rand96()) % pow10(s));
				return make_req(m[95:0], 8'(s), neg);
			end
			6, 7: begin
				// raw mantissa of random magnitude
				m = 128'(rand96() >> $urandom_range(0, 95));
				return make_req(m[95:0], 8'($urandom_range(0, 28)), neg);
			end
			8: begin
				// scale out of range
				return make_req(rand96(), 8'($urandom_range(29, 255)), neg);
			end
			default: begin
				return make_req(rand96(), 8'($urandom_range(0, 255)), neg);
			end
		endcase
	endfunction

	// present one request, hold it until taken, then record its result
	task automatic send_req(in_t r, out_t want);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_data  <= r;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(want);
	endtask

	// output stalls in random bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			stall_left = 0;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 10) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// compare each delivered result with the oldest pending one
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= MaxReports)
					$display("%0t: result with no request pending: value %0d error %0b",
						$time, out_data.int_value, out_data.error);
			end else begin
				want = pending_results.pop_front();
				if (out_data.error == ConvErr)
					err_cnt++;
				else
					ok_cnt++;
				if (out_data.int_value !== want.int_value || out_data.error !== want.error) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MaxReports)
						$display("%0t: mismatch: value exp %0d got %0d, error exp %0b got %0b",
							$time, want.int_value, out_data.int_value, want.error,
							out_data.error);
				end
			end
		end
	end

	// reset, directed table, random requests, drain and verdict
	initial begin
		in_t  r;
		out_t want;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		idle_on      = 1'b1;

		// values at the limits, wide words, bad scales
		dir_rows.push_back(make_row(make_req(96'd0, 8'd0, 1'b0), 1'b1, 32'd0, ConvOk));
		// negative zero
		dir_rows.push_back(make_row(make_req(96'd0, 8'd0, 1'b1), 1'b1, 32'd0, ConvOk));
		dir_rows.push_back(make_row(make_req(96'h7FFF_FFFF, 8'd0, 1'b0), 1'b1, IntMax,
			ConvOk));
		dir_rows.push_back(make_row(make_req(96'h7FFF_FFFF, 8'd0, 1'b1), 1'b1,
			32'h8000_0001, ConvOk));
		dir_rows.push_back(make_row(make_req(96'h8000_0000, 8'd0, 1'b0), 1'b1, 32'd0,
			ConvErr));
		// most negative value
		dir_rows.push_back(make_row(make_req(96'h8000_0000, 8'd0, 1'b1), 1'b1, IntMin,
			ConvOk));
		dir_rows.push_back(make_row(make_req(96'h8000_0001, 8'd0, 1'b1), 1'b1, 32'd0,
			ConvErr));
		dir_rows.push_back(make_row(make_req(96'hFFFF_FFFF, 8'd0, 1'b0), 1'b1, 32'd0,
			ConvErr));
		dir_rows.push_back(make_row(make_req(96'h1 << 32, 8'd0, 1'b0), 1'b1, 32'd0, ConvErr));
		dir_rows.push_back(make_row(make_req(96'h1 << 64, 8'd0, 1'b1), 1'b1, 32'd0, ConvErr));
		// scale just past the maximum and far past it
		dir_rows.push_back(make_row(make_req(96'd0, 8'd29, 1'b0), 1'b1, 32'd0, ConvErr));
		dir_rows.push_back(make_row(make_req('1, 8'd255, 1'b1), 1'b1, 32'd0, ConvErr));
		dir_rows.push_back(make_row(make_req(96'd5, 8'd128, 1'b0), 1'b1, 32'd0, ConvErr));
		// deepest division and values around the limit after one division
		dir_rows.push_back(make_row(make_req('1, 8'd28, 1'b0), 1'b0, 32'd0, ConvOk));
		dir_rows.push_back(make_row(make_req('1, 8'd28, 1'b1), 1'b0, 32'd0, ConvOk));
		dir_rows.push_back(make_row(make_req(96'(pow10(28)), 8'd28, 1'b0), 1'b0, 32'd0,
			ConvOk));
		dir_rows.push_back(make_row(make_req(96'(pow10(28) - 128'd1), 8'd28, 1'b1), 1'b0,
			32'd0, ConvOk));
		dir_rows.push_back(make_row(make_req(96'd21474836479, 8'd1, 1'b0), 1'b0, 32'd0,
			ConvOk));
		dir_rows.push_back(make_row(make_req(96'd21474836480, 8'd1, 1'b0), 1'b0, 32'd0,
			ConvOk));
		dir_rows.push_back(make_row(make_req(96'd21474836489, 8'd1, 1'b1), 1'b0, 32'd0,
			ConvOk));
		dir_rows.push_back(make_row(make_req(96'd21474836490, 8'd1, 1'b1), 1'b0, 32'd0,
			ConvOk));
		dir_rows.push_back(make_row(make_req(96'd12345, 8'd2, 1'b1), 1'b0, 32'd0, ConvOk));
		dir_rows.push_back(make_row(make_req(96'd9, 8'd1, 1'b0), 1'b0, 32'd0, ConvOk));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			want = dir_rows[i].typed ? dir_rows[i].want : truncate_to_int32(dir_rows[i].req);
			send_req(dir_rows[i].req, want);
		end

		for (int n = 0; n < RandomCount; n++) begin
			if (n == RandomCount - CalmTail)
				idle_on = 1'b0;
			r = random_req();
			send_req(r, truncate_to_int32(r));
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("%0d requests sent (%0d directed), %0d results in range, %0d flagged",
			dir_rows.size() + RandomCount, dir_rows.size(), ok_cnt, err_cnt);
		$display("%0d mismatches", mismatch_cnt);
		if (mismatch_cnt == 0 && pending_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("timeout with %0d results pending", pending_results.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
